[rtl/core/dsm_pkg.sv]
`timescale 1ns / 1ps
// dsm_pkg: constants, types and the job record of the decimal schoolbook multiplier
// no dependencies; used by every other file of the block

package dsm_pkg;

    localparam int DSM_OPD    = 10;                       // decimal digits kept per operand
    localparam int DSM_OPW    = 31;                       // operand width
    localparam int DSM_DGW    = 4;                        // width of one decimal digit
    localparam int DSM_LW     = $clog2(DSM_OPD + 1);      // digit count width
    localparam int DSM_IW     = (DSM_OPD > 1) ? $clog2(DSM_OPD) : 1;
    localparam int DSM_PD     = 2 * DSM_OPD + 1;          // product store depth
    localparam int DSM_PW     = $clog2(DSM_PD);
    localparam int DSM_MAXR   = 19;                       // most digits sent per request
    localparam int DSM_CW     = $clog2(DSM_MAXR);
    localparam int DSM_QDEPTH = 2;
    localparam int DSM_QPW    = (DSM_QDEPTH > 1) ? $clog2(DSM_QDEPTH) : 1;
    localparam int DSM_QCW    = $clog2(DSM_QDEPTH + 1);

    localparam logic [31:0] DSM_RECIP = 32'hCCCC_CCCD;   // ceil(2^35 / 10)

    typedef logic [DSM_DGW-1:0] t_digit;
    typedef t_digit [DSM_OPD-1:0] t_dvec;

    typedef struct packed {
        logic               zero;
        logic [DSM_LW-1:0]  la;
        logic [DSM_LW-1:0]  lb;
        t_dvec              da;
        t_dvec              db;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_SPLIT = 2'b10
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_MUL   = 4'b0010,
        B_STRIP = 4'b0100,
        B_EMIT  = 4'b1000
    } t_bstate;

endpackage

[rtl/core/dsm_if.sv]
`timescale 1ns / 1ps
// dsm_in_if and dsm_out_if: valid/ready channels for operands and product digits
// depends on dsm_pkg for field widths

interface dsm_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsm_pkg::DSM_OPW-1:0]   operand_a;
    logic [dsm_pkg::DSM_OPW-1:0]   operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface dsm_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsm_pkg::DSM_DGW-1:0]   digit;
    logic                          last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

[rtl/core/dsm_front.sv]
`timescale 1ns / 1ps
// dsm_front: takes an operand request, splits both operands into decimal digits
// one digit per cycle and hands a job to the queue; depends on dsm_pkg, dsm_if

module dsm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dsm_in_if.sink               i_op,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output dsm_pkg::t_job        o_push_job
);

    dsm_pkg::t_fstate               r_state;
    logic [dsm_pkg::DSM_OPW-1:0]    r_va;
    logic [dsm_pkg::DSM_OPW-1:0]    r_vb;
    logic [dsm_pkg::DSM_LW-1:0]     r_la;
    logic [dsm_pkg::DSM_LW-1:0]     r_lb;
    dsm_pkg::t_dvec                 r_da;
    dsm_pkg::t_dvec                 r_db;

    logic [dsm_pkg::DSM_OPW-1:0]    w_qa;
    logic [dsm_pkg::DSM_OPW-1:0]    w_qb;
    dsm_pkg::t_digit                w_ra;
    dsm_pkg::t_digit                w_rb;
    logic                           w_a_run;
    logic                           w_b_run;
    logic                           w_done;
    logic                           w_accept;

    // divide by ten through the reciprocal, exact for every 31-bit operand value
    function automatic logic [dsm_pkg::DSM_OPW-1:0] div10(
        input logic [dsm_pkg::DSM_OPW-1:0] v
    );
        logic [62:0] m;
        m = 63'(v) * 63'(dsm_pkg::DSM_RECIP);
        return dsm_pkg::DSM_OPW'(m[62:35]);
    endfunction

    always_comb begin
        w_qa    = div10(r_va);
        w_qb    = div10(r_vb);
        w_ra    = dsm_pkg::t_digit'(r_va - dsm_pkg::DSM_OPW'(w_qa * 31'd10));
        w_rb    = dsm_pkg::t_digit'(r_vb - dsm_pkg::DSM_OPW'(w_qb * 31'd10));
        w_a_run = (r_va != '0) && (r_la != dsm_pkg::DSM_LW'(dsm_pkg::DSM_OPD));
        w_b_run = (r_vb != '0) && (r_lb != dsm_pkg::DSM_LW'(dsm_pkg::DSM_OPD));
        w_done  = !w_a_run && !w_b_run;
    end

    assign i_op.ready   = (r_state == dsm_pkg::F_IDLE);
    assign w_accept     = i_op.valid && i_op.ready;
    assign o_push_valid = (r_state == dsm_pkg::F_SPLIT) && w_done;

    always_comb begin
        o_push_job.zero = (r_la == '0) || (r_lb == '0);
        o_push_job.la   = r_la;
        o_push_job.lb   = r_lb;
        o_push_job.da   = r_da;
        o_push_job.db   = r_db;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsm_pkg::F_IDLE;
        end else begin
            unique case (r_state)
                dsm_pkg::F_IDLE: begin
                    if (w_accept) begin
                        r_state <= dsm_pkg::F_SPLIT;
                    end
                end
                dsm_pkg::F_SPLIT: begin
                    if (w_done && i_push_ready) begin
                        r_state <= dsm_pkg::F_IDLE;
                    end
                end
                default: begin
                    r_state <= dsm_pkg::F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va <= i_op.operand_a;
            r_vb <= i_op.operand_b;
            r_la <= '0;
            r_lb <= '0;
        end else if (r_state == dsm_pkg::F_SPLIT) begin
            if (w_a_run) begin
                r_da[r_la[dsm_pkg::DSM_IW-1:0]] <= w_ra;
                r_va <= w_qa;
                r_la <= r_la + dsm_pkg::DSM_LW'(1);
            end
            if (w_b_run) begin
                r_db[r_lb[dsm_pkg::DSM_IW-1:0]] <= w_rb;
                r_vb <= w_qb;
                r_lb <= r_lb + dsm_pkg::DSM_LW'(1);
            end
        end
    end

endmodule

[rtl/core/dsm_queue.sv]
`timescale 1ns / 1ps
// dsm_queue: short job queue between the digit splitter and the multiplier
// depends on dsm_pkg

module dsm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  dsm_pkg::t_job        i_push_job,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output dsm_pkg::t_job        o_pop_job
);

    dsm_pkg::t_job                  r_mem [dsm_pkg::DSM_QDEPTH];
    logic [dsm_pkg::DSM_QPW-1:0]    r_wp;
    logic [dsm_pkg::DSM_QPW-1:0]    r_rp;
    logic [dsm_pkg::DSM_QCW-1:0]    r_cnt;
    logic                           w_push;
    logic                           w_pop;

    function automatic logic [dsm_pkg::DSM_QPW-1:0] ptr_inc(
        input logic [dsm_pkg::DSM_QPW-1:0] p
    );
        if (p == dsm_pkg::DSM_QPW'(dsm_pkg::DSM_QDEPTH - 1)) begin
            return '0;
        end
        return p + dsm_pkg::DSM_QPW'(1);
    endfunction

    assign o_push_ready = (r_cnt != dsm_pkg::DSM_QCW'(dsm_pkg::DSM_QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (w_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + dsm_pkg::DSM_QCW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - dsm_pkg::DSM_QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

[rtl/core/dsm_back.sv]
`timescale 1ns / 1ps
// dsm_back: digit-by-digit schoolbook multiply, leading zero strip and digit output
// depends on dsm_pkg, dsm_if

module dsm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  dsm_pkg::t_job        i_job,
    dsm_out_if.source            o_dig
);

    dsm_pkg::t_bstate               r_state;
    dsm_pkg::t_dvec                 r_da;
    dsm_pkg::t_dvec                 r_db;
    logic [dsm_pkg::DSM_LW-1:0]     r_la;
    logic [dsm_pkg::DSM_LW-1:0]     r_lb;
    logic [dsm_pkg::DSM_IW-1:0]     r_i;
    logic [dsm_pkg::DSM_IW-1:0]     r_j;
    dsm_pkg::t_digit                r_c;
    logic [dsm_pkg::DSM_PW-1:0]     r_idx;
    logic [dsm_pkg::DSM_CW-1:0]     r_cnt;
    logic                           r_zero;
    dsm_pkg::t_digit                r_prod [dsm_pkg::DSM_PD];
    logic                           r_ovalid;
    dsm_pkg::t_digit                r_odigit;
    logic                           r_olast;

    logic [dsm_pkg::DSM_PW-1:0]     w_rd_idx;
    logic [dsm_pkg::DSM_PW-1:0]     w_cy_idx;
    dsm_pkg::t_digit                w_rd;
    dsm_pkg::t_digit                w_old;
    logic [7:0]                     w_sum;
    logic [15:0]                    w_qm;
    dsm_pkg::t_digit                w_q;
    dsm_pkg::t_digit                w_r;
    logic                           w_row_end;
    logic                           w_col_end;
    logic                           w_load;
    logic                           w_last;
    logic                           w_take;

    always_comb begin
        unique case (r_state)
            dsm_pkg::B_MUL: w_rd_idx = dsm_pkg::DSM_PW'(r_i) + dsm_pkg::DSM_PW'(r_j);
            default:        w_rd_idx = r_idx;
        endcase
        w_rd      = r_prod[w_rd_idx];
        w_cy_idx  = dsm_pkg::DSM_PW'(r_i) + dsm_pkg::DSM_PW'(r_la);
        // first row reads an empty product
        w_old     = (r_i == '0) ? '0 : w_rd;
        w_sum     = 8'(w_old) + 8'(r_db[r_i]) * 8'(r_da[r_j]) + 8'(r_c);
        // sum stays below 100, so *205 >> 11 is an exact divide by ten
        w_qm      = 16'(w_sum) * 16'd205;
        w_q       = dsm_pkg::t_digit'(w_qm[15:11]);
        w_r       = dsm_pkg::t_digit'(w_sum - 8'(w_q * 8'd10));
        w_row_end = (r_j == dsm_pkg::DSM_IW'(r_la - dsm_pkg::DSM_LW'(1)));
        w_col_end = (r_i == dsm_pkg::DSM_IW'(r_lb - dsm_pkg::DSM_LW'(1)));
        w_load    = (r_state == dsm_pkg::B_EMIT) && (!r_ovalid || o_dig.ready);
        w_last    = r_zero || (r_idx == '0)
                    || (r_cnt == dsm_pkg::DSM_CW'(dsm_pkg::DSM_MAXR - 1));
    end

    assign o_job_ready      = (r_state == dsm_pkg::B_IDLE);
    assign w_take           = i_job_valid && o_job_ready;
    assign o_dig.valid      = r_ovalid;
    assign o_dig.digit      = r_odigit;
    assign o_dig.last_digit = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dsm_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            priority if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_dig.ready) begin
                r_ovalid <= 1'b0;
            end else begin
                r_ovalid <= r_ovalid;
            end
            unique case (r_state)
                dsm_pkg::B_IDLE: begin
                    if (w_take) begin
                        r_state <= i_job.zero ? dsm_pkg::B_EMIT : dsm_pkg::B_MUL;
                    end
                end
                dsm_pkg::B_MUL: begin
                    if (w_row_end && w_col_end) begin
                        r_state <= dsm_pkg::B_STRIP;
                    end
                end
                dsm_pkg::B_STRIP: begin
                    if (r_idx == '0 || w_rd != '0) begin
                        r_state <= dsm_pkg::B_EMIT;
                    end
                end
                dsm_pkg::B_EMIT: begin
                    if (w_load && w_last) begin
                        r_state <= dsm_pkg::B_IDLE;
                    end
                end
                default: begin
                    r_state <= dsm_pkg::B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odigit <= r_zero ? '0 : w_rd;
            r_olast  <= w_last;
        end
        unique case (r_state)
            dsm_pkg::B_IDLE: begin
                if (w_take) begin
                    r_da   <= i_job.da;
                    r_db   <= i_job.db;
                    r_la   <= i_job.la;
                    r_lb   <= i_job.lb;
                    r_zero <= i_job.zero;
                    r_i    <= '0;
                    r_j    <= '0;
                    r_c    <= '0;
                    r_cnt  <= '0;
                    r_idx  <= '0;
                end
            end
            dsm_pkg::B_MUL: begin
                r_prod[w_rd_idx] <= w_r;
                if (w_row_end) begin
                    r_prod[w_cy_idx] <= w_q;
                    r_j <= '0;
                    r_c <= '0;
                    r_i <= r_i + dsm_pkg::DSM_IW'(1);
                    r_idx <= dsm_pkg::DSM_PW'(r_la) + dsm_pkg::DSM_PW'(r_lb)
                             - dsm_pkg::DSM_PW'(1);
                end else begin
                    r_j <= r_j + dsm_pkg::DSM_IW'(1);
                    r_c <= w_q;
                end
            end
            dsm_pkg::B_STRIP: begin
                if (r_idx != '0 && w_rd == '0) begin
                    r_idx <= r_idx - dsm_pkg::DSM_PW'(1);
                end
            end
            dsm_pkg::B_EMIT: begin
                if (w_load && !w_last) begin
                    r_idx <= r_idx - dsm_pkg::DSM_PW'(1);
                    r_cnt <= r_cnt + dsm_pkg::DSM_CW'(1);
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

[rtl/core/decimal_schoolbook_multiplier_top.sv]
`timescale 1ns / 1ps
// decimal_schoolbook_multiplier_top: operand splitter, job queue and digit multiplier
// depends on dsm_pkg, dsm_if, dsm_front, dsm_queue, dsm_back
//
// channel   dir  fields                          handshake
// i_op      in   operand_a[30:0], operand_b[30:0] valid / ready
// o_dig     out  digit[3:0], last_digit           valid / ready
//
// the splitter takes one request, then splits both operands into decimal digits until
// the longer operand (up to 10 digits) is done, and hands the job to a two-entry queue.
// the multiplier takes the job, forms la*lb digit products (up to 100), strips leading zeros
// and emits digits most significant first (up to 19); a zero job emits a single 0 digit.
// reset is synchronous, active low; it empties the queue and idles both halves.
// a stalled output holds the multiplier; the splitter keeps working until the queue fills.

module decimal_schoolbook_multiplier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsm_in_if.sink      i_op,
    dsm_out_if.source   o_dig
);

    logic               w_push_valid;
    logic               w_push_ready;
    dsm_pkg::t_job      w_push_job;
    logic               w_pop_valid;
    logic               w_pop_ready;
    dsm_pkg::t_job      w_pop_job;

    dsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    dsm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    dsm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_pop_valid),
        .o_job_ready  (w_pop_ready),
        .i_job        (w_pop_job),
        .o_dig        (o_dig)
    );

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid |-> (o_dig.digit <= 4'd9))
        else $error("product digit out of decimal range");

    a_split_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.valid && i_op.ready) |=> !i_op.ready)
        else $error("splitter took a request while splitting");

    a_digit_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dig.valid && o_dig.ready && !o_dig.last_digit) |=> o_dig.valid)
        else $error("gap inside a product digit stream");

    a_zero_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_job.zero && w_push_job.la != '0 && w_push_job.lb != '0)
        |-> 1'b0)
        else $error("job flagged zero with digits on both operands");

endmodule
